@@ design/fan_speed_sequencer_assert.svh @@
// Assertion macros shared by the fan speed sequencer RTL.
// Each macro expects signals named clk and rst_n in the scope that uses it.
`ifndef FAN_SPEED_SEQUENCER_ASSERT_SVH
`define FAN_SPEED_SEQUENCER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define FSS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define FSS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/fss_pkg.sv @@
// Package for the fan speed sequencer: types, register indexes, command codes,
// reset values and the command decode function. No dependencies.
`default_nettype none

package fss_pkg;

    localparam int unsigned DUTY_W  = 7;
    localparam int unsigned TICKS_W = 16;
    localparam int unsigned MODE_W  = 16;
    localparam int unsigned CMD_W   = 5;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [MODE_W-1:0] ADJUST_MASK = 16'h0010;

    localparam logic [DUTY_W-1:0] DUTY_FULL = 7'd100;

    typedef enum logic [1:0] {
        FAN_OFF   = 2'd0,
        FAN_START = 2'd1,
        FAN_ON    = 2'd2
    } fan_state_t;

    localparam logic [CMD_W-1:0] CMD_OFF         = 5'd0;
    localparam logic [CMD_W-1:0] CMD_LEVEL_ONE   = 5'd1;
    localparam logic [CMD_W-1:0] CMD_LEVEL_TWO   = 5'd2;
    localparam logic [CMD_W-1:0] CMD_LEVEL_THREE = 5'd3;
    localparam logic [CMD_W-1:0] CMD_ADJUST      = 5'd16;

    localparam logic [CFG_IDX_W-1:0] REG_DUTY_OFF    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_ONE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_TWO   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_THREE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ADJUST_MAX  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_START  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_STEP   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_START_TICKS = 3'd7;

    localparam logic [DUTY_W-1:0]  RST_DUTY_OFF    = 7'd0;
    localparam logic [DUTY_W-1:0]  RST_LEVEL_ONE   = 7'd40;
    localparam logic [DUTY_W-1:0]  RST_LEVEL_TWO   = 7'd70;
    localparam logic [DUTY_W-1:0]  RST_LEVEL_THREE = 7'd100;
    localparam logic [DUTY_W-1:0]  RST_ADJUST_MAX  = 7'd100;
    localparam logic [DUTY_W-1:0]  RST_DUTY_START  = 7'd100;
    localparam logic [DUTY_W-1:0]  RST_DUTY_STEP   = 7'd1;
    localparam logic [TICKS_W-1:0] RST_START_TICKS = 16'd300;

    typedef struct packed {
        logic [DUTY_W-1:0]  duty_off;
        logic [DUTY_W-1:0]  level_one;
        logic [DUTY_W-1:0]  level_two;
        logic [DUTY_W-1:0]  level_three;
        logic [DUTY_W-1:0]  adjust_max;
        logic [DUTY_W-1:0]  duty_start;
        logic [DUTY_W-1:0]  duty_step;
        logic [TICKS_W-1:0] start_ticks;
    } fss_cfg_t;

    typedef struct packed {
        fan_state_t         status;
        logic [DUTY_W-1:0]  duty;
        logic [TICKS_W-1:0] count;
        logic [CMD_W-1:0]   last;
    } fss_state_t;

    // Applies one command to the sequencer state. The adjust ceiling is
    // picked by the two low bits of the stored mode.
    function automatic fss_state_t apply_cmd(fss_state_t s, logic [CMD_W-1:0] cmd,
                                             logic [1:0] sel, fss_cfg_t c);
        fss_state_t        r;
        logic [DUTY_W-1:0] ceil_duty;
        logic [DUTY_W:0]   sum;
        r   = s;
        sum = {1'b0, s.duty} + {1'b0, c.duty_step};
        case (sel)
            2'd0:    ceil_duty = c.duty_off;
            2'd1:    ceil_duty = c.adjust_max;
            2'd2:    ceil_duty = c.level_one;
            default: ceil_duty = c.level_two;
        endcase
        if (s.status == FAN_OFF) begin
            if (cmd != CMD_OFF) begin
                r.status = FAN_START;
                r.duty   = c.duty_start;
                r.count  = c.start_ticks;
            end
        end else if (cmd == CMD_OFF) begin
            r.status = FAN_OFF;
            r.duty   = c.duty_off;
        end else if (cmd <= CMD_LEVEL_THREE) begin
            r.status = FAN_ON;
            if (cmd == CMD_LEVEL_ONE) begin
                r.duty = c.level_one;
            end else if (cmd == CMD_LEVEL_TWO) begin
                r.duty = c.level_two;
            end else begin
                r.duty = c.level_three;
            end
        end else if (cmd == CMD_ADJUST) begin
            r.status = FAN_ON;
            if (s.duty < ceil_duty) begin
                if (sum > {1'b0, DUTY_FULL}) begin
                    r.duty = DUTY_FULL;
                end else begin
                    r.duty = sum[DUTY_W-1:0];
                end
            end
        end
        r.last = cmd;
        return r;
    endfunction

endpackage

`default_nettype wire

@@ design/fss_cfg_regs.sv @@
// Configuration register file of the fan speed sequencer.
// Depends on fss_pkg for the register indexes, reset values and fss_cfg_t.
`default_nettype none

module fss_cfg_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [fss_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [fss_pkg::TICKS_W-1:0]   cfg_data,
    output fss_pkg::fss_cfg_t                  cfg
);
    import fss_pkg::*;

    fss_cfg_t cfg_reg;
    fss_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_DUTY_OFF:    cfg_next.duty_off    = cfg_data[DUTY_W-1:0];
                REG_LEVEL_ONE:   cfg_next.level_one   = cfg_data[DUTY_W-1:0];
                REG_LEVEL_TWO:   cfg_next.level_two   = cfg_data[DUTY_W-1:0];
                REG_LEVEL_THREE: cfg_next.level_three = cfg_data[DUTY_W-1:0];
                REG_ADJUST_MAX:  cfg_next.adjust_max  = cfg_data[DUTY_W-1:0];
                REG_DUTY_START:  cfg_next.duty_start  = cfg_data[DUTY_W-1:0];
                REG_DUTY_STEP:   cfg_next.duty_step   = cfg_data[DUTY_W-1:0];
                REG_START_TICKS: cfg_next.start_ticks = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.duty_off    <= RST_DUTY_OFF;
            cfg_reg.level_one   <= RST_LEVEL_ONE;
            cfg_reg.level_two   <= RST_LEVEL_TWO;
            cfg_reg.level_three <= RST_LEVEL_THREE;
            cfg_reg.adjust_max  <= RST_ADJUST_MAX;
            cfg_reg.duty_start  <= RST_DUTY_START;
            cfg_reg.duty_step   <= RST_DUTY_STEP;
            cfg_reg.start_ticks <= RST_START_TICKS;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

@@ design/fan_speed_sequencer.sv @@
// Top level of the fan speed sequencer: input register, sequencing logic and result register.
// Depends on fss_pkg, fss_cfg_regs and fan_speed_sequencer_assert.svh.
`default_nettype none

// Each beat is a mode word or a time tick and yields exactly one result beat
// with the PWM compare value, the fan state and whether the compare value was
// written. A beat passes an input register and is decoded combinationally
// into the sequencer state and the result register, so the block sustains one
// beat per cycle while the result is not stalled; a stalled result still leaves
// room for one more beat in the input register. Configuration writes are
// taken every cycle and must only be issued while no beat is in flight.
module fan_speed_sequencer (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          op,
    input  wire logic [fss_pkg::MODE_W-1:0]    mode_word,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [fss_pkg::DUTY_W-1:0]         pwm_compare,
    output logic [1:0]                         fan_state,
    output logic                               compare_written,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [fss_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [fss_pkg::TICKS_W-1:0]   cfg_data
);
    import fss_pkg::*;

    `include "fan_speed_sequencer_assert.svh"

    fss_cfg_t cfg;

    logic              in_valid_reg;
    logic              op_reg;
    logic [MODE_W-1:0] mode_word_reg;
    logic              out_valid_reg;
    logic              written_reg;
    logic              written_next;

    fss_state_t        state_reg;
    fss_state_t        state_next;
    logic [MODE_W-1:0] prev_mode_reg;
    logic [MODE_W-1:0] prev_mode_next;
    logic [DUTY_W-1:0] compare_reg;
    logic [DUTY_W-1:0] compare_next;

    logic advance;
    logic take_item;

    fss_state_t after_mode;
    fss_state_t after_start;
    logic       mode_applied;
    logic       start_done;

    fss_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign advance   = !out_valid_reg || out_ready;
    assign take_item = in_valid_reg && advance;
    assign in_ready  = !in_valid_reg || advance;

    // Next-state logic: mode decode or tick, then the end of soft start.
    always_comb
    begin
        after_mode     = state_reg;
        prev_mode_next = prev_mode_reg;
        mode_applied   = 1'b0;
        if (!op_reg) begin
            if (mode_word_reg != prev_mode_reg) begin
                if ((mode_word_reg & ADJUST_MASK) == ADJUST_MASK) begin
                    after_mode     = apply_cmd(state_reg, CMD_ADJUST,
                                               mode_word_reg[1:0], cfg);
                    prev_mode_next = mode_word_reg & ~ADJUST_MASK;
                    mode_applied   = 1'b1;
                end else begin
                    prev_mode_next = mode_word_reg;
                    if (mode_word_reg[3:2] == 2'd0) begin
                        after_mode   = apply_cmd(state_reg,
                                                 {3'd0, mode_word_reg[1:0]},
                                                 mode_word_reg[1:0], cfg);
                        mode_applied = 1'b1;
                    end
                end
            end
        end else if (state_reg.count != '0) begin
            after_mode.count = state_reg.count - 1'b1;
        end

        after_start = after_mode;
        start_done  = 1'b0;
        if (after_mode.status == FAN_START && after_mode.count == '0) begin
            after_start.status = FAN_ON;
            after_start = apply_cmd(after_start, after_mode.last,
                                    prev_mode_next[1:0], cfg);
            start_done  = 1'b1;
        end

        state_next   = after_start;
        written_next = mode_applied || start_done;
        compare_next = written_next ? after_start.duty : compare_reg;
    end

    // Result outputs come straight from the state and result registers.
    always_comb
    begin
        out_valid       = out_valid_reg;
        pwm_compare     = compare_reg;
        fan_state       = state_reg.status;
        compare_written = written_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (in_ready) begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid) begin
            op_reg        <= op;
            mode_word_reg <= mode_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg   <= 1'b0;
            written_reg     <= 1'b0;
            state_reg.status <= FAN_OFF;
            state_reg.duty  <= RST_DUTY_OFF;
            state_reg.count <= '0;
            state_reg.last  <= CMD_OFF;
            prev_mode_reg   <= '0;
            compare_reg     <= RST_DUTY_OFF;
        end else begin
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            if (take_item) begin
                written_reg   <= written_next;
                state_reg     <= state_next;
                prev_mode_reg <= prev_mode_next;
                compare_reg   <= compare_next;
            end
        end
    end

    `FSS_ASSERT_NOW(a_start_has_ticks, state_reg.status == FAN_START,
                    state_reg.count != '0, "soft start held with zero countdown")
    `FSS_ASSERT_NOW(a_last_cmd_legal, state_reg.last[CMD_W-1],
                    state_reg.last == CMD_ADJUST, "stored command is not a known code")
    `FSS_ASSERT_NEXT(a_compare_kept, take_item && !written_next,
                     compare_reg == $past(compare_reg), "compare changed without a write")
    `FSS_ASSERT_NEXT(a_item_held, in_valid_reg && !advance,
                     in_valid_reg && $stable(mode_word_reg) && $stable(op_reg),
                     "buffered beat lost while result stalled")

endmodule

`default_nettype wire
